// File: sv/ecf_pkg.sv
// Shared types and constants for the epoch-seconds to calendar-fields converter.
// No dependencies. Imported by epoch_seconds_to_calendar_fields_top.

package ecf_pkg;

    // Calendar constants
    localparam longint unsigned SECS_PER_HOUR    = 64'd3600;
    localparam longint unsigned SECS_PER_MIN     = 64'd60;
    localparam longint unsigned DAYS_PER_ERA     = 64'd146097;
    localparam longint unsigned DAYS_PER_YEAR    = 64'd365;
    localparam longint unsigned DAYS_PER_WEEK    = 64'd7;
    localparam longint unsigned SHIFT_TO_MARCH   = 64'd719468;
    localparam longint unsigned DAYS_4Y          = 64'd1460;
    localparam longint unsigned DAYS_100Y        = 64'd36524;
    localparam longint unsigned DAYS_ERA_LAST    = 64'd146096;
    localparam longint unsigned YEARS_CENTURY    = 64'd100;
    localparam longint unsigned MP_SPAN          = 64'd153;
    localparam longint unsigned MP_STEP          = 64'd5;
    localparam longint unsigned MP_ROUND         = 64'd2;

    // 86400 = 128 * 675: low 7 bits split off by shift, rest divided by 675
    localparam int unsigned     SOD_SHIFT        = 7;
    localparam longint unsigned DIV_675          = 64'd675;

    // Bias so the 33-bit shifted seconds become non-negative (multiple of 675)
    localparam int unsigned     DAY_BIAS_LOG2    = 23;
    localparam longint unsigned SEC_BIAS         = DIV_675 << DAY_BIAS_LOG2;
    // Whole eras added so the March-based day number is non-negative
    localparam longint unsigned ERA_BIAS_COUNT   = 64'd64;
    localparam longint unsigned ERA_DAY_BIAS     = SHIFT_TO_MARCH
                                                 + DAYS_PER_ERA * ERA_BIAS_COUNT
                                                 - (64'd1 << DAY_BIAS_LOG2);

    // Reciprocals: floor(x/d) == (x * ceil(2^(n+l)/d)) >> (n+l), x < 2^n, d <= 2^l
    localparam int unsigned SH_675_HI = 27;   // 17-bit dividend
    localparam int unsigned SH_675_LO = 37;   // 27-bit dividend
    localparam int unsigned SH_ERA    = 43;   // 25-bit dividend
    localparam int unsigned SH_WEEK   = 28;   // 25-bit dividend
    localparam int unsigned SH_HOUR   = 29;   // 17-bit dividend
    localparam int unsigned SH_MIN    = 18;   // 12-bit dividend
    localparam int unsigned SH_4Y     = 29;   // 18-bit dividend
    localparam int unsigned SH_100Y   = 34;   // 18-bit dividend
    localparam int unsigned SH_ERAL   = 36;   // 18-bit dividend
    localparam int unsigned SH_YEAR   = 27;   // 18-bit dividend
    localparam int unsigned SH_CENT   = 16;   // 9-bit dividend
    localparam int unsigned SH_MP     = 19;   // 11-bit dividend
    localparam int unsigned SH_STEP   = 14;   // 11-bit dividend

    localparam logic [17:0] RCP_675_HI =
        18'(((64'd1 << SH_675_HI) + DIV_675 - 64'd1) / DIV_675);
    localparam logic [27:0] RCP_675_LO =
        28'(((64'd1 << SH_675_LO) + DIV_675 - 64'd1) / DIV_675);
    localparam logic [25:0] RCP_ERA    =
        26'(((64'd1 << SH_ERA) + DAYS_PER_ERA - 64'd1) / DAYS_PER_ERA);
    localparam logic [25:0] RCP_WEEK   =
        26'(((64'd1 << SH_WEEK) + DAYS_PER_WEEK - 64'd1) / DAYS_PER_WEEK);
    localparam logic [17:0] RCP_HOUR   =
        18'(((64'd1 << SH_HOUR) + SECS_PER_HOUR - 64'd1) / SECS_PER_HOUR);
    localparam logic [12:0] RCP_MIN    =
        13'(((64'd1 << SH_MIN) + SECS_PER_MIN - 64'd1) / SECS_PER_MIN);
    localparam logic [18:0] RCP_4Y     =
        19'(((64'd1 << SH_4Y) + DAYS_4Y - 64'd1) / DAYS_4Y);
    localparam logic [18:0] RCP_100Y   =
        19'(((64'd1 << SH_100Y) + DAYS_100Y - 64'd1) / DAYS_100Y);
    localparam logic [18:0] RCP_ERAL   =
        19'(((64'd1 << SH_ERAL) + DAYS_ERA_LAST - 64'd1) / DAYS_ERA_LAST);
    localparam logic [18:0] RCP_YEAR   =
        19'(((64'd1 << SH_YEAR) + DAYS_PER_YEAR - 64'd1) / DAYS_PER_YEAR);
    localparam logic [9:0]  RCP_CENT   =
        10'(((64'd1 << SH_CENT) + YEARS_CENTURY - 64'd1) / YEARS_CENTURY);
    localparam logic [11:0] RCP_MP     =
        12'(((64'd1 << SH_MP) + MP_SPAN - 64'd1) / MP_SPAN);
    localparam logic [11:0] RCP_STEP   =
        12'(((64'd1 << SH_STEP) + MP_STEP - 64'd1) / MP_STEP);

    // Month index from March (0) to calendar month
    localparam logic [3:0] MP_JANUARY  = 4'd10;
    localparam logic [3:0] MON_FROM_MAR = 4'd3;
    localparam logic [3:0] MON_FROM_JAN = 4'd9;

    localparam int unsigned NUM_STAGES = 11;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day_of_month;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [2:0] weekday;
    } cal_fields_t;

endpackage

// File: sv/epoch_seconds_to_calendar_fields_top.sv
// Epoch seconds to calendar fields: month, day of month, hour, minute, weekday.
// Depends on ecf_pkg (constants, reciprocals, cal_fields_t).
//
// Channel   Direction  Handshake          Payload
// --------  ---------  -----------------  ---------------------------------------------
// s_        in         s_valid / s_ready  s_epoch_seconds (40b signed)
// m_        out        m_valid / m_ready  m_month, m_day_of_month, m_hour, m_minute,
//                                         m_weekday
//
// One request per cycle sustained when nothing stalls: 11 pipeline stages plus an output
// register, so a result passes every stage in order and then shows on m_ from that register.
// Every stage takes a new request each cycle while ce is high; the widest stage, the 27x28
// reciprocal multiply for /675, bounds the clock speed, not the rate.
// Reset (aresetn low, synchronous) clears the stage valid bits, output and skid
// valids; data registers are not reset. A stall on m_ready parks one result in the
// skid register and then freezes the whole pipeline; s_ready comes straight from a flop.

module epoch_seconds_to_calendar_fields_top
    import ecf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [39:0] s_epoch_seconds,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_month,
    output logic [4:0]         m_day_of_month,
    output logic [4:0]         m_hour,
    output logic [5:0]         m_minute,
    output logic [2:0]         m_weekday
);

    // ------------------------------------------------------------------
    // Pipeline control: one global enable, held off only by a full skid.
    // ------------------------------------------------------------------
    logic                  ce;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;

    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    cal_fields_t           out_reg;
    cal_fields_t           skid_reg;
    logic                  out_free;
    logic                  pipe_take;

    assign ce         = !skid_valid_reg;
    assign s_ready    = ce;
    assign valid_next = {valid_reg[NUM_STAGES-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: seconds >> 7, bias to non-negative, high digit of /675.
    // Bias is 675 * 2^23, so days come out offset by 2^23.
    // ------------------------------------------------------------------
    logic [33:0] u1;
    logic [34:0] p1;
    logic [7:0]  s1_qh_reg;
    logic [16:0] s1_uh_reg;
    logic [16:0] s1_ul_reg;
    logic [6:0]  s1_r1_reg;

    assign u1 = {s_epoch_seconds[39], s_epoch_seconds[39:SOD_SHIFT]} + 34'(SEC_BIAS);
    assign p1 = 35'(u1[33:17]) * 35'(RCP_675_HI);

    // Stage 2: remainder of the high digit, joined with the low 17 bits
    logic [16:0] rh2;
    logic [26:0] s2_x_reg;
    logic [7:0]  s2_qh_reg;
    logic [6:0]  s2_r1_reg;

    assign rh2 = s1_uh_reg - 17'(s1_qh_reg) * 17'(DIV_675);

    // Stage 3: low digit of /675
    logic [54:0] p3;
    logic [16:0] s3_ql_reg;
    logic [26:0] s3_x_reg;
    logic [7:0]  s3_qh_reg;
    logic [6:0]  s3_r1_reg;

    assign p3 = 55'(s2_x_reg) * 55'(RCP_675_LO);

    // Stage 4: biased day number and seconds of the day
    logic [26:0] rl4;
    logic [24:0] s4_days_b_reg;
    logic [16:0] s4_sod_reg;

    assign rl4 = s3_x_reg - 27'(s3_ql_reg) * 27'(DIV_675);

    // Stage 5: era, week and hour quotients.
    // Biased days are congruent to days + 4 mod 7, so they give the weekday directly.
    logic [24:0] z5;
    logic [50:0] p5e;
    logic [50:0] p5w;
    logic [34:0] p5h;
    logic [24:0] s5_z_reg;
    logic [7:0]  s5_eq_reg;
    logic [24:0] s5_days_b_reg;
    logic [22:0] s5_wq_reg;
    logic [16:0] s5_sod_reg;
    logic [4:0]  s5_hr_reg;

    assign z5  = s4_days_b_reg + 25'(ERA_DAY_BIAS);
    assign p5e = 51'(z5) * 51'(RCP_ERA);
    assign p5w = 51'(s4_days_b_reg) * 51'(RCP_WEEK);
    assign p5h = 35'(s4_sod_reg) * 35'(RCP_HOUR);

    // Stage 6: day of era, weekday, seconds within the hour
    logic [24:0] doe6;
    logic [24:0] wd6;
    logic [16:0] msec6;
    logic [17:0] s6_doe_reg;
    logic [2:0]  s6_wd_reg;
    logic [11:0] s6_msec_reg;
    logic [4:0]  s6_hr_reg;

    assign doe6  = s5_z_reg - 25'(s5_eq_reg) * 25'(DAYS_PER_ERA);
    assign wd6   = s5_days_b_reg - 25'(s5_wq_reg) * 25'(DAYS_PER_WEEK);
    assign msec6 = s5_sod_reg - 17'(s5_hr_reg) * 17'(SECS_PER_HOUR);

    // Stage 7: leap corrections on day of era, minute
    logic [36:0] p7a;
    logic [36:0] p7b;
    logic [36:0] p7c;
    logic [24:0] p7m;
    logic [17:0] n7;
    cal_fields_t res7;
    logic [17:0] s7_n_reg;
    logic [17:0] s7_doe_reg;
    cal_fields_t s7_res_reg;

    assign p7a = 37'(s6_doe_reg) * 37'(RCP_4Y);
    assign p7b = 37'(s6_doe_reg) * 37'(RCP_100Y);
    assign p7c = 37'(s6_doe_reg) * 37'(RCP_ERAL);
    assign p7m = 25'(s6_msec_reg) * 25'(RCP_MIN);
    assign n7  = s6_doe_reg - 18'(p7a[35:SH_4Y]) + 18'(p7b[36:SH_100Y])
               - 18'(p7c[SH_ERAL]);

    always_comb begin
        res7              = '0;
        res7.hour         = s6_hr_reg;
        res7.minute       = p7m[23:SH_MIN];
        res7.weekday      = s6_wd_reg;
    end

    // Stage 8: year of era
    logic [36:0] p8;
    logic [8:0]  s8_yoe_reg;
    logic [17:0] s8_doe_reg;
    cal_fields_t s8_res_reg;

    assign p8 = 37'(s7_n_reg) * 37'(RCP_YEAR);

    // Stage 9: day of year from March 1
    logic [18:0] p9;
    logic [17:0] base9;
    logic [17:0] doy9;
    logic [8:0]  s9_doy_reg;
    cal_fields_t s9_res_reg;

    assign p9    = 19'(s8_yoe_reg) * 19'(RCP_CENT);
    assign base9 = 18'(s8_yoe_reg) * 18'(DAYS_PER_YEAR) + 18'(s8_yoe_reg[8:2])
                 - 18'(p9[18:SH_CENT]);
    assign doy9  = s8_doe_reg - base9;

    // Stage 10: month index from March
    logic [10:0] t10;
    logic [22:0] p10;
    logic [3:0]  s10_mp_reg;
    logic [8:0]  s10_doy_reg;
    cal_fields_t s10_res_reg;

    assign t10 = 11'(s9_doy_reg) * 11'(MP_STEP) + 11'(MP_ROUND);
    assign p10 = 23'(t10) * 23'(RCP_MP);

    // Stage 11: day of month and calendar month
    logic [10:0] t11;
    logic [22:0] p11;
    logic [8:0]  dom11;
    cal_fields_t res11;
    cal_fields_t s11_res_reg;

    assign t11   = 11'(s10_mp_reg) * 11'(MP_SPAN) + 11'(MP_ROUND);
    assign p11   = 23'(t11) * 23'(RCP_STEP);
    assign dom11 = s10_doy_reg - p11[22:SH_STEP] + 9'd1;

    always_comb begin
        res11              = s10_res_reg;
        res11.day_of_month = dom11[4:0];
        res11.month        = (s10_mp_reg < MP_JANUARY) ? s10_mp_reg + MON_FROM_MAR
                                                       : s10_mp_reg - MON_FROM_JAN;
    end

    // Data path registers, all advancing together
    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_qh_reg     <= p1[34:SH_675_HI];
            s1_uh_reg     <= u1[33:17];
            s1_ul_reg     <= u1[16:0];
            s1_r1_reg     <= s_epoch_seconds[SOD_SHIFT-1:0];

            s2_x_reg      <= {rh2[9:0], s1_ul_reg};
            s2_qh_reg     <= s1_qh_reg;
            s2_r1_reg     <= s1_r1_reg;

            s3_ql_reg     <= p3[53:SH_675_LO];
            s3_x_reg      <= s2_x_reg;
            s3_qh_reg     <= s2_qh_reg;
            s3_r1_reg     <= s2_r1_reg;

            s4_days_b_reg <= {s3_qh_reg, s3_ql_reg};
            s4_sod_reg    <= {rl4[9:0], s3_r1_reg};

            s5_z_reg      <= z5;
            s5_eq_reg     <= p5e[50:SH_ERA];
            s5_days_b_reg <= s4_days_b_reg;
            s5_wq_reg     <= p5w[50:SH_WEEK];
            s5_sod_reg    <= s4_sod_reg;
            s5_hr_reg     <= p5h[33:SH_HOUR];

            s6_doe_reg    <= doe6[17:0];
            s6_wd_reg     <= wd6[2:0];
            s6_msec_reg   <= msec6[11:0];
            s6_hr_reg     <= s5_hr_reg;

            s7_n_reg      <= n7;
            s7_doe_reg    <= s6_doe_reg;
            s7_res_reg    <= res7;

            s8_yoe_reg    <= p8[35:SH_YEAR];
            s8_doe_reg    <= s7_doe_reg;
            s8_res_reg    <= s7_res_reg;

            s9_doy_reg    <= doy9[8:0];
            s9_res_reg    <= s8_res_reg;

            s10_mp_reg    <= p10[22:SH_MP];
            s10_doy_reg   <= s9_doy_reg;
            s10_res_reg   <= s9_res_reg;

            s11_res_reg   <= res11;
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid. The last stage is consumed whenever ce is
    // high; it goes to the output if that is free, else into the skid.
    // ------------------------------------------------------------------
    assign out_free  = !out_valid_reg || m_ready;
    assign pipe_take = valid_reg[NUM_STAGES-1] && ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || pipe_take;
            skid_valid_reg <= 1'b0;
        end else if (pipe_take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= skid_valid_reg ? skid_reg : s11_res_reg;
        end else if (pipe_take) begin
            skid_reg <= s11_res_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_month        = out_reg.month;
    assign m_day_of_month = out_reg.day_of_month;
    assign m_hour         = out_reg.hour;
    assign m_minute       = out_reg.minute;
    assign m_weekday      = out_reg.weekday;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Skid only holds a result while the output register is occupied
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full while output empty");

    // Skid fills only when the output was blocked in the cycle before
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("skid filled without a blocked output");

    // A stalled pipeline keeps its occupancy and last-stage data
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !ce |=> $stable(valid_reg) && $stable(s11_res_reg))
        else $error("pipeline moved during stall");

    // Every delivered result is a legal calendar field set
    a_fields_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month >= 4'd1) && (m_month <= 4'd12)
                 && (m_day_of_month >= 5'd1) && (m_hour <= 5'd23)
                 && (m_minute <= 6'd59) && (m_weekday <= 3'd6))
        else $error("result field out of range");

endmodule
